### design/register_file_alu_executor_macros.svh
// Assertion macros for the register file ALU executor checker
`ifndef REGISTER_FILE_ALU_EXECUTOR_MACROS_SVH
`define REGISTER_FILE_ALU_EXECUTOR_MACROS_SVH
// Immediate implication under reset
`define RFAE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under reset
`define RFAE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/rfae_pkg.sv
// Package: types, op codes and constants of the register file ALU executor
`default_nettype none
package rfae_pkg;
  localparam int RegCount   = 16;
  localparam int StackDepth = 256;
  localparam int RegIdxW    = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int StkAddrW   = $clog2(StackDepth);
  localparam int StkCntW    = StkAddrW + 1;

  typedef enum logic [4:0] {
    OP_LDC = 5'd0, OP_CMP = 5'd1, OP_PUSH = 5'd2, OP_POP = 5'd3, OP_MOV = 5'd4,
    OP_SQRT = 5'd5, OP_NOT = 5'd6, OP_ADD = 5'd7, OP_MUL = 5'd8, OP_SUB = 5'd9,
    OP_OR = 5'd10, OP_XOR = 5'd11, OP_AND = 5'd12, OP_SHL = 5'd13, OP_SHR = 5'd14,
    OP_DIV = 5'd15, OP_MOD = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ARITH = 3'd1, ST_OVFL = 3'd2, ST_UNFL = 3'd3, ST_BADMODE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_ITER, S_WRITE, S_OUT
  } state_e;

  typedef struct packed {
    logic [4:0]  mode;
    logic [3:0]  dest_index;
    logic [3:0]  src_a_index;
    logic [3:0]  src_b_index;
    logic [63:0] immediate;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wrote_register;
    logic [63:0] written_value;
    logic        flag_equal;
    logic        flag_less;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic read;     // read operands
    logic exec;     // single-cycle ops and iteration setup
    logic iter;     // one iteration step
    logic write;    // commit result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic iterative;
    logic iter_done;
  } stat_t;

  // register index reduced modulo the register count
  function automatic logic [RegIdxW-1:0] reg_sel(input logic [3:0] idx);
    logic [31:0] r;
    r = 32'(idx) % RegCount;
    return r[RegIdxW-1:0];
  endfunction
endpackage
`default_nettype wire

### design/rfae_stream_if.sv
// Valid/ready channel interface carrying one beat of payload
`default_nettype none
interface rfae_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/rfae_ctrl.sv
// Controller: sequences read, execute, iterate, write-back and output
`default_nettype none
module rfae_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire rfae_pkg::stat_t stat_i,
  output rfae_pkg::ctrl_t     ctrl_o
);
  rfae_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfae_pkg::S_IDLE:  if (in_valid_i) state_d = rfae_pkg::S_READ;
      rfae_pkg::S_READ:  state_d = rfae_pkg::S_EXEC;
      rfae_pkg::S_EXEC:  state_d = stat_i.iterative ? rfae_pkg::S_ITER : rfae_pkg::S_WRITE;
      rfae_pkg::S_ITER:  if (stat_i.iter_done) state_d = rfae_pkg::S_WRITE;
      rfae_pkg::S_WRITE: state_d = rfae_pkg::S_OUT;
      rfae_pkg::S_OUT:   if (out_ready_i) state_d = rfae_pkg::S_IDLE;
      default:           state_d = rfae_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == rfae_pkg::S_IDLE);
    out_valid_o  = (state_q == rfae_pkg::S_OUT);
    ctrl_o.load  = (state_q == rfae_pkg::S_IDLE) && in_valid_i;
    ctrl_o.read  = (state_q == rfae_pkg::S_READ);
    ctrl_o.exec  = (state_q == rfae_pkg::S_EXEC);
    ctrl_o.iter  = (state_q == rfae_pkg::S_ITER);
    ctrl_o.write = (state_q == rfae_pkg::S_WRITE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfae_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

### design/rfae_datapath.sv
// Datapath: register file, stack memory, ALU and bit-serial divide / root unit
`default_nettype none
module rfae_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rfae_pkg::ctrl_t    ctrl_i,
  input  wire rfae_pkg::in_beat_t in_i,
  output rfae_pkg::stat_t         stat_o,
  output rfae_pkg::out_beat_t     out_o
);
  localparam int IdxW = rfae_pkg::RegIdxW;
  localparam int AW   = rfae_pkg::StkAddrW;
  localparam int CW   = rfae_pkg::StkCntW;

  logic [63:0] rf_q [rfae_pkg::RegCount];
  logic [63:0] stk_mem [rfae_pkg::StackDepth];
  logic [CW-1:0] cnt_q;
  logic [1:0] flags_q;

  logic [4:0] mode_q;
  logic [IdxW-1:0] d_q, a_q, b_q;
  logic [63:0] imm_q, va_q, vb_q, vd_q, stk_rd_q;
  logic [63:0] res_q;
  logic [2:0] status_q;
  logic wr_q;

  // iterative unit state
  logic [63:0] quo_q, rem_q, dvs_q, root_q, bit_q, num_q;
  logic [6:0]  it_q;
  logic neg_q;

  // capture beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q <= in_i.mode;
      d_q    <= rfae_pkg::reg_sel(in_i.dest_index);
      a_q    <= rfae_pkg::reg_sel(in_i.src_a_index);
      b_q    <= rfae_pkg::reg_sel(in_i.src_b_index);
      imm_q  <= in_i.immediate;
    end
  end

  // operand read, stack read at top - 1
  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      va_q <= rf_q[a_q];
      vb_q <= rf_q[b_q];
      vd_q <= rf_q[d_q];
    end
  end
  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - CW'(1);
  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) stk_rd_q <= stk_mem[cnt_m1[AW-1:0]];
  end

  logic is_div, is_sqrt;
  assign is_div  = (mode_q == rfae_pkg::OP_DIV || mode_q == rfae_pkg::OP_MOD) && vb_q != 64'd0;
  assign is_sqrt = (mode_q == rfae_pkg::OP_SQRT) && !va_q[63];
  assign stat_o.iterative = is_div || is_sqrt;
  assign stat_o.iter_done = (it_q == 7'd0);

  // magnitudes
  logic [63:0] ma, mb;
  assign ma = va_q[63] ? (64'd0 - va_q) : va_q;
  assign mb = vb_q[63] ? (64'd0 - vb_q) : vb_q;

  // one restoring step
  logic [64:0] trial;
  logic [63:0] shrem;
  logic [63:0] rt_sum;
  assign shrem  = {rem_q[62:0], quo_q[63]};
  assign trial  = {1'b0, shrem} - {1'b0, dvs_q};
  assign rt_sum = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      it_q <= is_div ? 7'd64 : 7'd32;
      quo_q <= ma;
      rem_q <= '0;
      dvs_q <= mb;
      num_q <= va_q;
      root_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
      neg_q <= (mode_q == rfae_pkg::OP_DIV) ? (va_q[63] ^ vb_q[63]) : va_q[63];
    end else if (ctrl_i.iter && it_q != 7'd0) begin
      it_q <= it_q - 7'd1;
      if (mode_q == rfae_pkg::OP_SQRT) begin
        if (num_q >= rt_sum) begin
          num_q  <= num_q - rt_sum;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= shrem;
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
    end
  end

  // multiplier: 64x64 low half from three 32x32 products registered in the read state
  logic [63:0] pll_q, plh_q, phl_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      pll_q <= rf_q[a_q][31:0] * rf_q[b_q][31:0];
      plh_q <= 64'(rf_q[a_q][31:0] * rf_q[b_q][63:32]);
      phl_q <= 64'(rf_q[a_q][63:32] * rf_q[b_q][31:0]);
    end
  end

  // results and status for every mode
  logic [63:0] res_d;
  logic [2:0] st_d;
  logic wr_d;
  logic [63:0] dq;
  assign dq = (mode_q == rfae_pkg::OP_DIV) ? quo_q : rem_q;
  always_comb begin
    res_d = '0;
    st_d  = rfae_pkg::ST_OK;
    wr_d  = 1'b0;
    unique case (mode_q)
      rfae_pkg::OP_LDC:  begin res_d = imm_q; wr_d = 1'b1; end
      rfae_pkg::OP_CMP:  ;
      rfae_pkg::OP_PUSH: if (cnt_q >= CW'(rfae_pkg::StackDepth)) st_d = rfae_pkg::ST_OVFL;
      rfae_pkg::OP_POP:
        if (cnt_q == '0) st_d = rfae_pkg::ST_UNFL;
        else begin res_d = stk_rd_q; wr_d = 1'b1; end
      rfae_pkg::OP_MOV:  begin res_d = va_q; wr_d = 1'b1; end
      rfae_pkg::OP_SQRT:
        if (va_q[63]) st_d = rfae_pkg::ST_ARITH;
        else begin res_d = root_q; wr_d = 1'b1; end
      rfae_pkg::OP_NOT:  begin res_d = ~va_q; wr_d = 1'b1; end
      rfae_pkg::OP_ADD:  begin res_d = va_q + vb_q; wr_d = 1'b1; end
      rfae_pkg::OP_MUL:  begin
        res_d = pll_q + {plh_q[31:0] + phl_q[31:0], 32'd0}; wr_d = 1'b1;
      end
      rfae_pkg::OP_SUB:  begin res_d = va_q - vb_q; wr_d = 1'b1; end
      rfae_pkg::OP_OR:   begin res_d = va_q | vb_q; wr_d = 1'b1; end
      rfae_pkg::OP_XOR:  begin res_d = va_q ^ vb_q; wr_d = 1'b1; end
      rfae_pkg::OP_AND:  begin res_d = va_q & vb_q; wr_d = 1'b1; end
      rfae_pkg::OP_SHL:  begin
        res_d = (vb_q[63:6] != '0) ? 64'd0 : (va_q << vb_q[5:0]); wr_d = 1'b1;
      end
      rfae_pkg::OP_SHR:  begin
        res_d = (vb_q[63:6] != '0) ? 64'd0 : (va_q >> vb_q[5:0]); wr_d = 1'b1;
      end
      rfae_pkg::OP_DIV, rfae_pkg::OP_MOD:
        if (vb_q == '0) st_d = rfae_pkg::ST_ARITH;
        else begin res_d = neg_q ? (64'd0 - dq) : dq; wr_d = 1'b1; end
      default: st_d = rfae_pkg::ST_BADMODE;
    endcase
  end

  // commit: register file, flags, stack
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      res_q    <= wr_d ? res_d : 64'd0;
      wr_q     <= wr_d;
      status_q <= st_d;
      if (mode_q == rfae_pkg::OP_PUSH && st_d == rfae_pkg::ST_OK)
        stk_mem[cnt_q[AW-1:0]] <= vd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rfae_pkg::RegCount; i++) rf_q[i] <= '0;
      flags_q <= '0;
      cnt_q   <= '0;
    end else if (ctrl_i.write) begin
      if (wr_d) rf_q[d_q] <= res_d;
      if (mode_q == rfae_pkg::OP_CMP)
        flags_q <= {($signed(vd_q) < $signed(va_q)), (vd_q == va_q)};
      if (mode_q == rfae_pkg::OP_PUSH && st_d == rfae_pkg::ST_OK) cnt_q <= cnt_q + CW'(1);
      if (mode_q == rfae_pkg::OP_POP && st_d == rfae_pkg::ST_OK) cnt_q <= cnt_m1;
    end
  end

  assign out_o.status         = status_q;
  assign out_o.wrote_register = wr_q;
  assign out_o.written_value  = res_q;
  assign out_o.flag_equal     = flags_q[0];
  assign out_o.flag_less      = flags_q[1];
endmodule
`default_nettype wire

### design/register_file_alu_executor.sv
// Top level: register file ALU executor with bounded register stack
// channel | dir | payload
// in_if   | in  | mode, dest_index, src_a_index, src_b_index, immediate
// out_if  | out | status, wrote_register, written_value, flag_equal, flag_less
// One beat at a time, through the read, execute, write-back and output states.
// div/mod with a nonzero divisor and sqrt of a non-negative value also iterate in the bit-serial restoring unit.
// rst_ni clears registers, flags and stack count asynchronously.
// A stalled output holds the block; no new beat is taken until it leaves.
`default_nettype none
module register_file_alu_executor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfae_stream_if.sink   in_if,
  rfae_stream_if.source out_if
);
  rfae_pkg::ctrl_t ctrl;
  rfae_pkg::stat_t stat;

  rfae_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  rfae_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .in_i(in_if.data),
    .stat_o(stat), .out_o(out_if.data)
  );
endmodule
`default_nettype wire

### design/rfae_checker.sv
// Port-level checker for the register file ALU executor, with bind
`default_nettype none
`include "register_file_alu_executor_macros.svh"
module rfae_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] status,
  input wire logic wrote,
  input wire logic [63:0] value
);
  `RFAE_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid, !in_ready)
  `RFAE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(value))
  `RFAE_ASSERT_IMP(a_nowr, clk_i, rst_ni, out_valid && !wrote, value == 64'd0)
  `RFAE_ASSERT_IMP(a_fault, clk_i, rst_ni, out_valid && status != rfae_pkg::ST_OK, !wrote)
  `RFAE_ASSERT_NXT(a_acc, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind register_file_alu_executor rfae_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .status(out_if.data.status), .wrote(out_if.data.wrote_register),
  .value(out_if.data.written_value)
);
`default_nettype wire

### tb/sv/register_file_alu_executor_tb.sv
// Testbench for the register file ALU executor: random and directed instruction beats
`timescale 1ns / 100ps
`default_nettype none
module register_file_alu_executor_tb;

  localparam int RandomItems   = 560;
  localparam int QuietLimit    = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rfae_stream_if #(.T(rfae_pkg::in_beat_t))  instr_ch ();
  rfae_stream_if #(.T(rfae_pkg::out_beat_t)) result_ch ();

  register_file_alu_executor dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (instr_ch.sink),
    .out_if(result_ch.source)
  );

  // shadow machine state
  logic [63:0] shadow_regs [rfae_pkg::RegCount];
  logic [63:0] shadow_stack [rfae_pkg::StackDepth];
  int          shadow_depth;
  logic        shadow_eq;
  logic        shadow_lt;

  rfae_pkg::in_beat_t  pending_instrs [$];
  rfae_pkg::out_beat_t expected_results [$];
  int        mismatch_count;
  int        instrs_sent;
  int        results_seen;
  int        quiet_cycles;
  bit        stimulus_done;
  bit        no_idle;
  int        send_gap;
  int        recv_gap;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor integer square root, bit by bit
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // execute one instruction on the shadow state, return the expected beat
  function automatic rfae_pkg::out_beat_t execute_instr(input rfae_pkg::in_beat_t ins);
    rfae_pkg::out_beat_t r;
    logic [63:0] va, vb, vd, res, q, rem;
    int          d;
    bit          wr;
    logic [2:0]  st;
    d   = rfae_pkg::reg_sel(ins.dest_index);
    va  = shadow_regs[rfae_pkg::reg_sel(ins.src_a_index)];
    vb  = shadow_regs[rfae_pkg::reg_sel(ins.src_b_index)];
    vd  = shadow_regs[d];
    res = '0;
    wr  = 1'b0;
    st  = rfae_pkg::ST_OK;
    case (ins.mode)
      rfae_pkg::OP_LDC: begin res = ins.immediate; wr = 1'b1; end
      rfae_pkg::OP_CMP: begin
        shadow_eq = (vd == va);
        shadow_lt = ($signed(vd) < $signed(va));
      end
      rfae_pkg::OP_PUSH: begin
        if (shadow_depth >= rfae_pkg::StackDepth) begin
          st = rfae_pkg::ST_OVFL;
        end else begin
          shadow_stack[shadow_depth] = vd;
          shadow_depth++;
        end
      end
      rfae_pkg::OP_POP: begin
        if (shadow_depth == 0) begin
          st = rfae_pkg::ST_UNFL;
        end else begin
          shadow_depth--;
          res = shadow_stack[shadow_depth];
          wr = 1'b1;
        end
      end
      rfae_pkg::OP_MOV:  begin res = va; wr = 1'b1; end
      rfae_pkg::OP_SQRT: begin
        if (va[63]) st = rfae_pkg::ST_ARITH;
        else begin res = floor_root(va); wr = 1'b1; end
      end
      rfae_pkg::OP_NOT: begin res = ~va; wr = 1'b1; end
      rfae_pkg::OP_ADD: begin res = va + vb; wr = 1'b1; end
      rfae_pkg::OP_MUL: begin res = va * vb; wr = 1'b1; end
      rfae_pkg::OP_SUB: begin res = va - vb; wr = 1'b1; end
      rfae_pkg::OP_OR:  begin res = va | vb; wr = 1'b1; end
      rfae_pkg::OP_XOR: begin res = va ^ vb; wr = 1'b1; end
      rfae_pkg::OP_AND: begin res = va & vb; wr = 1'b1; end
      rfae_pkg::OP_SHL: begin res = (vb >= 64) ? '0 : va << vb[5:0]; wr = 1'b1; end
      rfae_pkg::OP_SHR: begin res = (vb >= 64) ? '0 : va >> vb[5:0]; wr = 1'b1; end
      rfae_pkg::OP_DIV, rfae_pkg::OP_MOD: begin
        if (vb == 0) begin
          st = rfae_pkg::ST_ARITH;
        end else begin
          q   = magnitude(va) / magnitude(vb);
          rem = magnitude(va) % magnitude(vb);
          if (ins.mode == rfae_pkg::OP_DIV) res = (va[63] ^ vb[63]) ? -q : q;
          else res = va[63] ? -rem : rem;
          wr = 1'b1;
        end
      end
      default: st = rfae_pkg::ST_BADMODE;
    endcase
    if (wr) shadow_regs[d] = res;
    else res = '0;
    r.status         = st;
    r.wrote_register = wr;
    r.written_value  = res;
    r.flag_equal     = shadow_eq;
    r.flag_less      = shadow_lt;
    return r;
  endfunction

  function automatic rfae_pkg::in_beat_t make_instr(input logic [4:0] op, input int d,
                                                    input int a, input int b,
                                                    input logic [63:0] imm);
    rfae_pkg::in_beat_t ins;
    ins.mode        = op;
    ins.dest_index  = d[3:0];
    ins.src_a_index = a[3:0];
    ins.src_b_index = b[3:0];
    ins.immediate   = imm;
    return ins;
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = '0;
      4: v = 64'($urandom_range(0, 80));
      5: v = -64'($urandom_range(1, 80));
      6: v = 64'($urandom_range(0, 1000000));
      default: ;
    endcase
    return v;
  endfunction

  // pick an operation; stack-heavy sequences reach full and empty states
  function automatic logic [4:0] rand_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return rfae_pkg::OP_LDC;
    if (p < 30) return rfae_pkg::OP_PUSH;
    if (p < 42) return rfae_pkg::OP_POP;
    if (p < 45) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(rfae_pkg::OP_CMP, rfae_pkg::OP_MOD));
  endfunction

  // stimulus
  initial begin
    int k;
    // pop the empty stack, then load extremes into registers
    pending_instrs.push_back(make_instr(rfae_pkg::OP_POP, 0, 0, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_LDC, 1, 0, 0, 64'h8000_0000_0000_0000));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_LDC, 2, 0, 0, '1));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_LDC, 3, 0, 0, 64'h7fff_ffff_ffff_ffff));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_LDC, 4, 0, 0, 64'd64));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_LDC, 5, 0, 0, 64'd63));
    // most negative by -1
    pending_instrs.push_back(make_instr(rfae_pkg::OP_DIV, 6, 1, 2, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_MOD, 7, 1, 2, '0));
    // divide by zero
    pending_instrs.push_back(make_instr(rfae_pkg::OP_DIV, 7, 3, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_MOD, 7, 3, 0, '0));
    // negative and largest positive root
    pending_instrs.push_back(make_instr(rfae_pkg::OP_SQRT, 8, 2, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_SQRT, 8, 3, 0, '0));
    // shifts by 64, 63 and all ones
    pending_instrs.push_back(make_instr(rfae_pkg::OP_SHL, 9, 2, 4, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_SHR, 9, 2, 5, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_SHL, 9, 2, 2, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_CMP, 1, 3, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_CMP, 3, 3, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_PUSH, 3, 0, 0, '0));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_POP, 15, 0, 0, '0));
    pending_instrs.push_back(make_instr(5'd31, 15, 15, 15, '1));
    pending_instrs.push_back(make_instr(rfae_pkg::OP_NOT, 10, 0, 0, '0));
    for (k = rfae_pkg::OP_MOV; k <= rfae_pkg::OP_SUB; k++)
      pending_instrs.push_back(make_instr(k[4:0], 11, 3, 2, '0));
    // fill the stack past full, then drain past empty
    for (k = 0; k < rfae_pkg::StackDepth + 2; k++)
      pending_instrs.push_back(make_instr(rfae_pkg::OP_PUSH, $urandom_range(0, 15), 0, 0, '0));
    for (k = 0; k < rfae_pkg::StackDepth + 2; k++)
      pending_instrs.push_back(make_instr(rfae_pkg::OP_POP, $urandom_range(0, 15), 0, 0, '0));
    for (k = 0; k < RandomItems; k++) begin
      pending_instrs.push_back(make_instr(rand_op(), $urandom_range(0, 15),
                                          $urandom_range(0, 15), $urandom_range(0, 15),
                                          rand_value()));
      if (k == RandomItems / 2) begin
        // let everything in flight drain before going on
        wait (pending_instrs.size() == 0 && expected_results.size() == 0);
      end
    end
    stimulus_done = 1'b1;
  end

  initial begin
    for (int i = 0; i < rfae_pkg::RegCount; i++) shadow_regs[i] = '0;
    for (int i = 0; i < rfae_pkg::StackDepth; i++) shadow_stack[i] = '0;
    shadow_depth   = 0;
    shadow_eq      = 1'b0;
    shadow_lt      = 1'b0;
    mismatch_count = 0;
    instrs_sent    = 0;
    results_seen   = 0;
    quiet_cycles   = 0;
    stimulus_done  = 1'b0;
    no_idle        = 1'b0;
    send_gap       = 0;
    recv_gap       = 0;
    instr_ch.valid  = 1'b0;
    instr_ch.data   = '0;
    result_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (instr_ch.valid && instr_ch.ready) begin
        void'(pending_instrs.pop_front());
        expected_results.push_back(execute_instr(instr_ch.data));
        instrs_sent++;
      end
      // no idling over the tail of the run
      if (stimulus_done && pending_instrs.size() < 200) no_idle = 1'b1;
      if (instr_ch.valid && !instr_ch.ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        instr_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 12);
        instr_ch.valid <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= pending_instrs[0];
      end else begin
        instr_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and ready generation
  always @(posedge clk_i) begin
    rfae_pkg::out_beat_t exp_r;
    if (rst_ni) begin
      quiet_cycles++;
      if (instr_ch.valid && instr_ch.ready) quiet_cycles = 0;
      if (result_ch.valid && result_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat %p", result_ch.data);
        end else begin
          exp_r = expected_results.pop_front();
          if (result_ch.data !== exp_r) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d mismatch: expected %p, got %p",
                       results_seen, exp_r, result_ch.data);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 12);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("register_file_alu_executor_tb: done, errors");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done && pending_instrs.size() == 0 && !instr_ch.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("ran %0d instruction beats and checked %0d result beats,", instrs_sent,
             results_seen);
    $display("covering all ops, faults, stack full/empty and bad modes");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("register_file_alu_executor_tb: done, clean");
    end else begin
      $display("register_file_alu_executor_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
